>>> rtl/core/dtrd_pkg.sv
// Shared types, constants and codes for the debounced threshold reflex detector.
package dtrd_pkg;

	localparam int NUM_CHANNELS_DEF    = 8;
	localparam int DEBOUNCE_NEEDED_DEF = 3;

	localparam logic        [15:0] DEFAULT_PT = 16'd8000;
	localparam logic signed [15:0] DEFAULT_TT = 16'sd450;
	localparam logic        [9:0]  FULL_SCALE = 10'd1000;
	localparam logic        [4:0]  TEMP_GAIN  = 5'd10;

	// quotient is 11 bits wide, enough to tell 1000 from anything above it
	localparam int QUOT_W = 11;
	localparam int DIV_W  = 15;
	localparam int NUM_W  = DIV_W + QUOT_W;
	localparam int STEP_W = $clog2(QUOT_W);

	localparam int CFG_ADDR_W = 3;
	localparam logic REG_IDX_PT = 1'b0;
	localparam logic REG_IDX_TT = 1'b1;

	typedef struct packed {
		logic        [15:0] pt;
		logic signed [15:0] tt;
	} thresh_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic check;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic sat;
		logic div_last;
		logic eos;
		logic out_free;
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PREP   = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

endpackage

>>> rtl/core/dtrd_in_if.sv
// Sample channel: one pressure/temperature reading per request.
interface dtrd_in_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  channel;
	logic        [15:0] pressure;
	logic signed [15:0] temperature_dc;
	logic               end_of_scan;

	modport source (output valid, channel, pressure, temperature_dc, end_of_scan,
		input ready);
	modport sink (input valid, channel, pressure, temperature_dc, end_of_scan,
		output ready);
endinterface

>>> rtl/core/dtrd_out_if.sv
// Scan result channel: one request per completed scan.
interface dtrd_out_if;
	logic        valid;
	logic        ready;
	logic        scan_detected;
	logic [2:0]  scan_zone;
	logic [9:0]  scan_intensity;
	logic        reflex_state;
	logic        new_event;
	logic [31:0] event_count;

	modport source (output valid, scan_detected, scan_zone, scan_intensity, reflex_state,
		new_event, event_count, input ready);
	modport sink (input valid, scan_detected, scan_zone, scan_intensity, reflex_state,
		new_event, event_count, output ready);
endinterface

>>> rtl/core/dtrd_cfg.sv
// APB threshold registers with zero-selects-default decode.
module dtrd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dtrd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output dtrd_pkg::thresh_t               thr
);

	logic [15:0] pt_q;
	logic [15:0] tt_q;
	logic        wr_en;
	logic        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= dtrd_pkg::DEFAULT_PT;
			tt_q <= dtrd_pkg::DEFAULT_TT;
		end else if (wr_en) begin
			unique case (reg_idx)
				dtrd_pkg::REG_IDX_PT: pt_q <= pwdata[15:0];
				dtrd_pkg::REG_IDX_TT: tt_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dtrd_pkg::REG_IDX_PT: prdata = {16'd0, pt_q};
			dtrd_pkg::REG_IDX_TT: prdata = {16'd0, tt_q};
			default:              prdata = '0;
		endcase
	end

	assign thr.pt = (pt_q == '0) ? dtrd_pkg::DEFAULT_PT : pt_q;
	assign thr.tt = (tt_q == '0) ? dtrd_pkg::DEFAULT_TT : $signed(tt_q);

endmodule

>>> rtl/core/dtrd_dp.sv
// Datapath: debounce counters, intensity terms, quotient loop, scan winner and reflex latch.
module dtrd_dp #(
	parameter int NUM_CHANNELS    = dtrd_pkg::NUM_CHANNELS_DEF,
	parameter int DEBOUNCE_NEEDED = dtrd_pkg::DEBOUNCE_NEEDED_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic        [2:0]  channel,
	input  logic        [15:0] pressure,
	input  logic signed [15:0] temperature_dc,
	input  logic               end_of_scan,
	input  dtrd_pkg::thresh_t  thr,
	input  dtrd_pkg::cmd_t     cmd,
	output dtrd_pkg::status_t  sts,
	dtrd_out_if.source         result
);

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DB_W     = $clog2(DEBOUNCE_NEEDED + 1);
	localparam logic [DB_W-1:0] DB_MAX = DB_W'(DEBOUNCE_NEEDED);
	localparam int QW = dtrd_pkg::QUOT_W;
	localparam int NW = dtrd_pkg::NUM_W;
	localparam int DW = dtrd_pkg::DIV_W;
	localparam int SW = dtrd_pkg::STEP_W;

	// sample registers
	logic        [2:0]  ch_q;
	logic        [15:0] p_q;
	logic signed [15:0] t_q;
	logic               eos_q;
	logic        [15:0] pt_q;
	logic signed [15:0] tt_q;

	logic [DB_W-1:0] db_cnt_q [NUM_CHANNELS];

	// per-sample terms
	logic          qual_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] div_q;
	logic [9:0]    it_q;
	logic [QW-1:0] quot_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dsh_q;
	logic [SW-1:0] step_q;

	// scan state
	logic [9:0]  best_int_q;
	logic [2:0]  best_ch_q;
	logic        best_found_q;
	logic        active_q;
	logic [31:0] evt_cnt_q;

	logic                ch_ok;
	logic [CH_IDX_W-1:0] idx;
	logic                over_p;
	logic                over_t;
	logic [DB_W-1:0]     cnt_cur;
	logic [DB_W-1:0]     cnt_new;
	logic                qual_n;
	logic [DW-1:0]       div_n;
	logic [15:0]         p_diff;
	logic [NW-1:0]       num_n;
	logic signed [16:0]  t_diff;
	logic [19:0]         t_mul;
	logic [9:0]          it_n;

	logic          sat;
	logic [NW-1:0] div_top;
	logic          rem_ge;

	logic [9:0]  ip;
	logic [9:0]  m_int;
	logic        take;
	logic [9:0]  best_int_n;
	logic [2:0]  best_ch_n;
	logic        best_found_n;
	logic        rfx;
	logic        started;
	logic        out_free;

	always_comb begin
		ch_ok   = {3'd0, ch_q} < 6'(NUM_CHANNELS);
		idx     = CH_IDX_W'(ch_q);
		over_p  = p_q >= pt_q;
		over_t  = t_q >= tt_q;
		cnt_cur = db_cnt_q[idx];
		if (over_p || over_t)
			cnt_new = (cnt_cur < DB_MAX) ? cnt_cur + 1'b1 : cnt_cur;
		else
			cnt_new = '0;
		qual_n = ch_ok && (cnt_new >= DB_MAX);
		div_n  = pt_q[15:1];
		p_diff = p_q - pt_q;
		num_n  = NW'(p_diff) * NW'(dtrd_pkg::FULL_SCALE);
		// t >= tt keeps the difference within 0..65535
		t_diff = 17'(t_q) - 17'(tt_q);
		t_mul  = 20'(t_diff[15:0]) * 20'(dtrd_pkg::TEMP_GAIN);
		if (!over_t)
			it_n = '0;
		else if (t_mul > 20'(dtrd_pkg::FULL_SCALE))
			it_n = dtrd_pkg::FULL_SCALE;
		else
			it_n = t_mul[9:0];
	end

	// quotient fits QW bits only below div << QW; above that it saturates anyway
	assign div_top = {div_q, {QW{1'b0}}};
	assign sat     = num_q >= div_top;
	assign rem_ge  = rem_q >= dsh_q;

	always_comb begin
		ip = (quot_q > QW'(dtrd_pkg::FULL_SCALE)) ? dtrd_pkg::FULL_SCALE : quot_q[9:0];
		m_int = (ip > it_q) ? ip : it_q;
		take  = qual_q && (m_int > best_int_q);
		best_int_n   = take ? m_int : best_int_q;
		best_ch_n    = take ? ch_q : best_ch_q;
		best_found_n = take | best_found_q;
		rfx     = best_found_n && (best_int_n != '0);
		started = rfx && !active_q;
	end

	assign out_free = !result.valid || result.ready;

	assign sts.need_div = qual_n && over_p && (div_n != '0);
	assign sts.sat      = sat;
	assign sts.div_last = (step_q == '0);
	assign sts.eos      = eos_q;
	assign sts.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= channel;
			p_q   <= pressure;
			t_q   <= temperature_dc;
			eos_q <= end_of_scan;
			pt_q  <= thr.pt;
			tt_q  <= thr.tt;
		end
		if (cmd.prep) begin
			qual_q <= qual_n;
			num_q  <= num_n;
			div_q  <= div_n;
			it_q   <= it_n;
			// threshold of one leaves a zero divisor: full scale
			quot_q <= (over_p && div_n == '0) ? QW'(dtrd_pkg::FULL_SCALE) : '0;
		end
		if (cmd.check) begin
			quot_q <= sat ? QW'(dtrd_pkg::FULL_SCALE) : '0;
			rem_q  <= num_q;
			dsh_q  <= div_top >> 1;
			step_q <= SW'(QW - 1);
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? rem_q - dsh_q : rem_q;
			quot_q <= {quot_q[QW-2:0], rem_ge};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++)
				db_cnt_q[i] <= '0;
		end else if (cmd.prep && ch_ok) begin
			db_cnt_q[idx] <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_int_q   <= '0;
			best_ch_q    <= '0;
			best_found_q <= 1'b0;
			active_q     <= 1'b0;
			evt_cnt_q    <= '0;
			result.valid <= 1'b0;
		end else begin
			if (result.ready)
				result.valid <= 1'b0;
			if (cmd.finish) begin
				if (eos_q) begin
					best_int_q   <= '0;
					best_ch_q    <= '0;
					best_found_q <= 1'b0;
					active_q     <= rfx;
					evt_cnt_q    <= evt_cnt_q + 32'(started);
					result.valid <= 1'b1;
				end else begin
					best_int_q   <= best_int_n;
					best_ch_q    <= best_ch_n;
					best_found_q <= best_found_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && eos_q) begin
			result.scan_detected  <= rfx;
			result.scan_zone      <= rfx ? best_ch_n : '0;
			result.scan_intensity <= rfx ? best_int_n : '0;
			result.reflex_state   <= rfx;
			result.new_event      <= started;
			result.event_count    <= evt_cnt_q + 32'(started);
		end
	end

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		best_int_q <= dtrd_pkg::FULL_SCALE)
		else $error("scan best intensity above full scale");

	a_scan_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && eos_q |=> best_int_q == '0 && !best_found_q && result.valid)
		else $error("end of scan did not clear winner or post result");

	a_event_active: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.new_event |-> result.reflex_state && result.scan_detected)
		else $error("reflex start reported without active reflex");

endmodule

>>> rtl/core/dtrd_ctrl.sv
// Controller: sequences load, prepare, saturation check, quotient loop and finish.
module dtrd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dtrd_pkg::status_t sts,
	output dtrd_pkg::cmd_t    cmd
);

	dtrd_pkg::state_t state_q;
	dtrd_pkg::state_t state_n;
	logic             accept;
	logic             fin_ok;

	assign in_ready = (state_q == dtrd_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	// a closing sample waits here until the result register is free
	assign fin_ok   = !sts.eos || sts.out_free;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			dtrd_pkg::ST_IDLE:   if (accept) state_n = dtrd_pkg::ST_PREP;
			dtrd_pkg::ST_PREP:   state_n = sts.need_div ? dtrd_pkg::ST_CHECK
				: dtrd_pkg::ST_FINISH;
			dtrd_pkg::ST_CHECK:  state_n = sts.sat ? dtrd_pkg::ST_FINISH : dtrd_pkg::ST_DIV;
			dtrd_pkg::ST_DIV:    if (sts.div_last) state_n = dtrd_pkg::ST_FINISH;
			dtrd_pkg::ST_FINISH: if (fin_ok) state_n = dtrd_pkg::ST_IDLE;
			default:             state_n = dtrd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dtrd_pkg::ST_IDLE;
		else
			state_q <= state_n;
	end

	assign cmd.load     = accept;
	assign cmd.prep     = (state_q == dtrd_pkg::ST_PREP);
	assign cmd.check    = (state_q == dtrd_pkg::ST_CHECK);
	assign cmd.div_step = (state_q == dtrd_pkg::ST_DIV);
	assign cmd.finish   = (state_q == dtrd_pkg::ST_FINISH) && fin_ok;

	a_accept_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == dtrd_pkg::ST_PREP)
		else $error("accepted sample not prepared");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dtrd_pkg::ST_DIV && !sts.div_last |=> state_q == dtrd_pkg::ST_DIV)
		else $error("quotient loop left early");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> in_ready)
		else $error("not ready after finishing a sample");

endmodule

>>> rtl/core/debounced_threshold_reflex_detector.sv
// Top level: reflex detector with APB threshold registers.
//
// Samples arrive on the sample channel (valid/ready), one channel reading per
// request, in ascending channel order; end_of_scan marks the last of a scan.
// One result request leaves on the result channel per scan, at the sample that
// carries end_of_scan; other samples produce no result.
// Accepted, a sample passes the prepare state, then finish if no pressure
// quotient is needed; else a saturation check, then finish if the quotient
// saturates, else the 11-step restoring divide for the pressure term (one
// quotient bit per cycle through one 26-bit subtractor) before finish. Ready
// is high only in the idle state. The result register and its valid flag load
// together when finish ends. The result sits in its own register, so the next
// samples are taken while it waits; a closing sample holds in its final cycle
// until that register frees. Thresholds are written over APB (pressure 0x0,
// temperature 0x4) by the user only while the block is idle, which the block
// does not enforce; zero selects the built-in default. Reset clears the
// debounce counters, the scan winner, the reflex latch and the event counter,
// and restores both threshold registers to their defaults.
module debounced_threshold_reflex_detector #(
	parameter int NUM_CHANNELS    = dtrd_pkg::NUM_CHANNELS_DEF,
	parameter int DEBOUNCE_NEEDED = dtrd_pkg::DEBOUNCE_NEEDED_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dtrd_in_if.sink                         sample,
	dtrd_out_if.source                      result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dtrd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	dtrd_pkg::thresh_t thr;
	dtrd_pkg::cmd_t    cmd;
	dtrd_pkg::status_t sts;
	logic              in_ready;

	assign sample.ready = in_ready;

	dtrd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	dtrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtrd_dp #(
		.NUM_CHANNELS    (NUM_CHANNELS),
		.DEBOUNCE_NEEDED (DEBOUNCE_NEEDED)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.channel        (sample.channel),
		.pressure       (sample.pressure),
		.temperature_dc (sample.temperature_dc),
		.end_of_scan    (sample.end_of_scan),
		.thr            (thr),
		.cmd            (cmd),
		.sts            (sts),
		.result         (result)
	);

endmodule
